// File: rtl/i2cms_pkg.sv
// ----------------------------------------------------------------------------
// i2cms_pkg
// types and constants shared by the i2c master transfer sequencer modules
// ----------------------------------------------------------------------------
package i2cms_pkg;

  // request kinds carried by req_type
  typedef enum logic [1:0] {
    REQ_TX_BYTE = 2'd0,
    REQ_READ    = 2'd1,
    REQ_STATUS  = 2'd2,
    REQ_FETCH   = 2'd3
  } op_t;

  // bus status codes as reported by the bus controller
  localparam logic [3:0] ST_START       = 4'd0;
  localparam logic [3:0] ST_RSTART      = 4'd1;
  localparam logic [3:0] ST_ADDR_W_ACK  = 4'd2;
  localparam logic [3:0] ST_ADDR_W_NACK = 4'd3;
  localparam logic [3:0] ST_DATA_ACK    = 4'd4;
  localparam logic [3:0] ST_DATA_NACK   = 4'd5;
  localparam logic [3:0] ST_RX_ACK      = 4'd8;
  localparam logic [3:0] ST_RX_NACK     = 4'd9;

  // classified bus events
  typedef enum logic [2:0] {
    EV_NONE,
    EV_START,
    EV_ADDR_W,
    EV_DATA_TX,
    EV_RX_ACK,
    EV_RX_NACK
  } ev_t;

  // command handed from the front to the back
  typedef struct packed {
    op_t        op;
    logic [6:0] slave_address;
    logic [7:0] data_byte;
    logic       last_byte;
    logic [3:0] read_length;
    ev_t        ev;
    logic [3:0] fetch_index;
    logic       read_ok;
    logic       fetch_ok;
  } cmd_t;

  // one result item
  typedef struct packed {
    logic       accepted;
    logic       load_data;
    logic [7:0] load_value;
    logic       send_start;
    logic       clear_start;
    logic       send_stop;
    logic       ack_enabled;
    logic       irq_enabled;
    logic       release_flag;
    logic [7:0] fetched_byte;
    logic [3:0] received_count;
  } res_t;

  // command queue geometry
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

endpackage

// File: rtl/i2cms_req_if.sv
// ----------------------------------------------------------------------------
// i2cms_req_if
// request channel: valid/ready handshake with one request per beat
// ----------------------------------------------------------------------------
interface i2cms_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [6:0] slave_address;
  logic [7:0] data_byte;
  logic       last_byte;
  logic [3:0] read_length;
  logic [3:0] bus_status;
  logic [3:0] fetch_index;

  modport source (
    output valid, req_type, slave_address, data_byte, last_byte, read_length,
           bus_status, fetch_index,
    input  ready
  );

  modport sink (
    input  valid, req_type, slave_address, data_byte, last_byte, read_length,
           bus_status, fetch_index,
    output ready
  );
endinterface

// File: rtl/i2cms_res_if.sv
// ----------------------------------------------------------------------------
// i2cms_res_if
// result channel: valid/ready handshake with one result per beat
// ----------------------------------------------------------------------------
interface i2cms_res_if;
  logic       valid;
  logic       ready;
  logic       accepted;
  logic       load_data;
  logic [7:0] load_value;
  logic       send_start;
  logic       clear_start;
  logic       send_stop;
  logic       ack_enabled;
  logic       irq_enabled;
  logic       release_flag;
  logic [7:0] fetched_byte;
  logic [3:0] received_count;

  modport source (
    output valid, accepted, load_data, load_value, send_start, clear_start,
           send_stop, ack_enabled, irq_enabled, release_flag, fetched_byte,
           received_count,
    input  ready
  );

  modport sink (
    input  valid, accepted, load_data, load_value, send_start, clear_start,
           send_stop, ack_enabled, irq_enabled, release_flag, fetched_byte,
           received_count,
    output ready
  );
endinterface

// File: rtl/i2cms_ram.sv
// ----------------------------------------------------------------------------
// i2cms_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module i2cms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/i2cms_front.sv
// ----------------------------------------------------------------------------
// i2cms_front
// accepts requests, classifies them and hands commands to the queue
// ----------------------------------------------------------------------------
module i2cms_front #(
  parameter int RX_DEPTH = 16
) (
  i2cms_req_if.sink         req,
  input  logic              q_full,
  output logic              push,
  output i2cms_pkg::cmd_t   cmd
);

  localparam logic [7:0] RX_LIMIT = 8'(RX_DEPTH);

  i2cms_pkg::ev_t ev;

  assign req.ready = !q_full;
  assign push      = req.valid && !q_full;

  // fold the bus status code into the events the back acts on
  always_comb begin
    case (req.bus_status)
      i2cms_pkg::ST_START,
      i2cms_pkg::ST_RSTART:      ev = i2cms_pkg::EV_START;
      i2cms_pkg::ST_ADDR_W_ACK,
      i2cms_pkg::ST_ADDR_W_NACK: ev = i2cms_pkg::EV_ADDR_W;
      i2cms_pkg::ST_DATA_ACK,
      i2cms_pkg::ST_DATA_NACK:   ev = i2cms_pkg::EV_DATA_TX;
      i2cms_pkg::ST_RX_ACK:      ev = i2cms_pkg::EV_RX_ACK;
      i2cms_pkg::ST_RX_NACK:     ev = i2cms_pkg::EV_RX_NACK;
      default:                   ev = i2cms_pkg::EV_NONE;
    endcase
  end

  always_comb begin
    cmd.op            = i2cms_pkg::op_t'(req.req_type);
    cmd.slave_address = req.slave_address;
    cmd.data_byte     = req.data_byte;
    cmd.last_byte     = req.last_byte;
    cmd.read_length   = req.read_length;
    cmd.ev            = ev;
    cmd.fetch_index   = req.fetch_index;
    cmd.read_ok       = {4'd0, req.read_length} < RX_LIMIT;
    cmd.fetch_ok      = {4'd0, req.fetch_index} < RX_LIMIT;
  end

endmodule

// File: rtl/i2cms_queue.sv
// ----------------------------------------------------------------------------
// i2cms_queue
// short command queue between front and back
// ----------------------------------------------------------------------------
module i2cms_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  i2cms_pkg::cmd_t push_cmd,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output i2cms_pkg::cmd_t head_cmd
);

  i2cms_pkg::cmd_t                   entry_r [i2cms_pkg::QDEPTH];
  logic [i2cms_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [i2cms_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [i2cms_pkg::QCNT_W-1:0]      count_r, count_nxt;

  assign full       = count_r == i2cms_pkg::QCNT_W'(i2cms_pkg::QDEPTH);
  assign head_valid = count_r != '0;
  assign head_cmd   = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// File: rtl/i2cms_back.sv
// ----------------------------------------------------------------------------
// i2cms_back
// executes queued commands against the sequencer state and drives results
// ----------------------------------------------------------------------------
module i2cms_back #(
  parameter int TX_DEPTH = 16,
  parameter int RX_DEPTH = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            head_valid,
  input  i2cms_pkg::cmd_t head_cmd,
  output logic            pop,
  i2cms_res_if.source     res
);

  localparam int TXC_W = $clog2(TX_DEPTH + 1);
  localparam int TXA_W = $clog2(TX_DEPTH);
  localparam int RXA_W = $clog2(RX_DEPTH);

  // sequencer state
  logic [TXC_W-1:0] tx_fill_r, tx_fill_nxt;
  logic [TXC_W-1:0] tx_pos_r,  tx_pos_nxt;
  logic [TXC_W-1:0] tx_len_r,  tx_len_nxt;
  logic [3:0]       rx_pos_r,  rx_pos_nxt;
  logic [3:0]       rx_len_r,  rx_len_nxt;
  logic [7:0]       addr_r,    addr_nxt;
  logic             ack_on_r,  ack_on_nxt;
  logic             irq_on_r,  irq_on_nxt;

  // execute stage waiting for ram data
  logic             p1_valid_r, p1_valid_nxt;
  i2cms_pkg::res_t  p1_res_r, exe_res;
  logic             p1_use_tx_r, exe_use_tx;
  logic             p1_use_rx_r, exe_use_rx;

  // output register
  logic             out_valid_r, out_valid_nxt;
  i2cms_pkg::res_t  out_res_r, fin_res;

  logic             p1_adv;
  logic             tx_we, rx_we;
  logic [TXC_W-1:0] fill_plus;
  logic [7:0]       rx_wa_wide, rx_ra_wide;
  logic [7:0]       tx_rd_data, rx_rd_data;

  assign p1_adv = !out_valid_r || res.ready;
  assign pop    = head_valid && (!p1_valid_r || p1_adv);

  assign fill_plus  = tx_fill_r + 1'b1;
  assign rx_wa_wide = {4'd0, rx_pos_r};
  assign rx_ra_wide = {4'd0, head_cmd.fetch_index};

  i2cms_ram #(.WIDTH(8), .DEPTH(TX_DEPTH)) u_tx_ram (
    .clk     (clk),
    .wr_en   (tx_we),
    .wr_addr (tx_fill_r[TXA_W-1:0]),
    .wr_data (head_cmd.data_byte),
    .rd_en   (pop),
    .rd_addr (tx_pos_r[TXA_W-1:0]),
    .rd_data (tx_rd_data)
  );

  i2cms_ram #(.WIDTH(8), .DEPTH(RX_DEPTH)) u_rx_ram (
    .clk     (clk),
    .wr_en   (rx_we),
    .wr_addr (rx_wa_wide[RXA_W-1:0]),
    .wr_data (head_cmd.data_byte),
    .rd_en   (pop),
    .rd_addr (rx_ra_wide[RXA_W-1:0]),
    .rd_data (rx_rd_data)
  );

  always_comb begin
    tx_fill_nxt = tx_fill_r;
    tx_pos_nxt  = tx_pos_r;
    tx_len_nxt  = tx_len_r;
    rx_pos_nxt  = rx_pos_r;
    rx_len_nxt  = rx_len_r;
    addr_nxt    = addr_r;
    ack_on_nxt  = ack_on_r;
    irq_on_nxt  = irq_on_r;
    tx_we       = 1'b0;
    rx_we       = 1'b0;
    exe_use_tx  = 1'b0;
    exe_use_rx  = 1'b0;
    exe_res     = '0;

    if (pop) begin
      case (head_cmd.op)
        i2cms_pkg::REQ_TX_BYTE: begin
          if (tx_len_r != '0) begin
            // write still pending
          end else if (tx_fill_r >= TXC_W'(TX_DEPTH)) begin
            tx_fill_nxt = '0;
          end else begin
            tx_we            = 1'b1;
            exe_res.accepted = 1'b1;
            tx_fill_nxt      = fill_plus;
            if (head_cmd.last_byte) begin
              tx_len_nxt         = fill_plus;
              tx_fill_nxt        = '0;
              addr_nxt           = {head_cmd.slave_address, 1'b0};
              irq_on_nxt         = 1'b1;
              exe_res.send_start = 1'b1;
            end
          end
        end
        i2cms_pkg::REQ_READ: begin
          if (head_cmd.read_ok) begin
            addr_nxt           = {head_cmd.slave_address, 1'b1};
            rx_len_nxt         = head_cmd.read_length;
            rx_pos_nxt         = '0;
            irq_on_nxt         = 1'b1;
            ack_on_nxt         = 1'b1;
            exe_res.send_start = 1'b1;
            exe_res.accepted   = 1'b1;
          end
        end
        i2cms_pkg::REQ_STATUS: begin
          exe_res.accepted     = 1'b1;
          exe_res.release_flag = 1'b1;
          case (head_cmd.ev)
            i2cms_pkg::EV_START: begin
              exe_res.load_data   = 1'b1;
              exe_res.load_value  = addr_r;
              exe_res.clear_start = 1'b1;
            end
            i2cms_pkg::EV_ADDR_W: begin
              exe_res.load_data = 1'b1;
              if (tx_pos_r < TXC_W'(TX_DEPTH)) begin
                exe_use_tx = 1'b1;
                tx_pos_nxt = tx_pos_r + 1'b1;
              end
            end
            i2cms_pkg::EV_DATA_TX: begin
              if (tx_pos_r < tx_len_r) begin
                exe_res.load_data = 1'b1;
                exe_use_tx        = 1'b1;
                tx_pos_nxt        = tx_pos_r + 1'b1;
              end else begin
                tx_pos_nxt        = '0;
                tx_len_nxt        = '0;
                exe_res.send_stop = 1'b1;
              end
            end
            i2cms_pkg::EV_RX_ACK: begin
              if (rx_pos_r < rx_len_r) begin
                rx_we      = 1'b1;
                rx_pos_nxt = rx_pos_r + 1'b1;
              end else begin
                ack_on_nxt = 1'b0;
              end
            end
            i2cms_pkg::EV_RX_NACK: begin
              exe_res.send_stop = 1'b1;
            end
            default: begin
            end
          endcase
        end
        i2cms_pkg::REQ_FETCH: begin
          exe_res.accepted = 1'b1;
          exe_use_rx       = head_cmd.fetch_ok;
        end
        default: begin
        end
      endcase
      exe_res.ack_enabled    = ack_on_nxt;
      exe_res.irq_enabled    = irq_on_nxt;
      exe_res.received_count = rx_len_nxt;
    end
  end

  // merge the ram read data into the waiting result
  always_comb begin
    fin_res = p1_res_r;
    if (p1_use_tx_r) begin
      fin_res.load_value = tx_rd_data;
    end
    if (p1_use_rx_r) begin
      fin_res.fetched_byte = rx_rd_data;
    end
  end

  always_comb begin
    if (pop) begin
      p1_valid_nxt = 1'b1;
    end else if (p1_adv) begin
      p1_valid_nxt = 1'b0;
    end else begin
      p1_valid_nxt = p1_valid_r;
    end
    out_valid_nxt = p1_adv ? p1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_fill_r   <= '0;
      tx_pos_r    <= '0;
      tx_len_r    <= '0;
      rx_pos_r    <= '0;
      rx_len_r    <= '0;
      addr_r      <= '0;
      ack_on_r    <= 1'b0;
      irq_on_r    <= 1'b0;
      p1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      tx_fill_r   <= tx_fill_nxt;
      tx_pos_r    <= tx_pos_nxt;
      tx_len_r    <= tx_len_nxt;
      rx_pos_r    <= rx_pos_nxt;
      rx_len_r    <= rx_len_nxt;
      addr_r      <= addr_nxt;
      ack_on_r    <= ack_on_nxt;
      irq_on_r    <= irq_on_nxt;
      p1_valid_r  <= p1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      p1_res_r    <= exe_res;
      p1_use_tx_r <= exe_use_tx;
      p1_use_rx_r <= exe_use_rx;
    end
    if (p1_adv && p1_valid_r) begin
      out_res_r <= fin_res;
    end
  end

  assign res.valid          = out_valid_r;
  assign res.accepted       = out_res_r.accepted;
  assign res.load_data      = out_res_r.load_data;
  assign res.load_value     = out_res_r.load_value;
  assign res.send_start     = out_res_r.send_start;
  assign res.clear_start    = out_res_r.clear_start;
  assign res.send_stop      = out_res_r.send_stop;
  assign res.ack_enabled    = out_res_r.ack_enabled;
  assign res.irq_enabled    = out_res_r.irq_enabled;
  assign res.release_flag   = out_res_r.release_flag;
  assign res.fetched_byte   = out_res_r.fetched_byte;
  assign res.received_count = out_res_r.received_count;

endmodule

// File: rtl/i2c_master_transfer_sequencer_core.sv
// ----------------------------------------------------------------------------
// i2c_master_transfer_sequencer_core
// interrupt-driven i2c master sequencer: collects write messages, arms
// reads, answers bus status events with bus controls, returns received bytes
// ----------------------------------------------------------------------------
//
//   channel   dir   beat content
//   --------  ----  ---------------------------------------------------------
//   in_req    in    one request: tx byte, start read, bus status or fetch
//   out_res   out   one result per request: bus controls, levels, fetch data
//
// one request per cycle sustained while out_res is not stalled; the front, the
// command queue and the back each take one beat per cycle
// a result beat passes the queue, the execute stage with its store read and
// the output register on its way to out_res
// reset is synchronous and clears all control state; the byte stores are
// not cleared, an entry is meaningful only once written
// out_res stalls fill the output register, the execute stage and the queue
// before in_req.ready drops
//
module i2c_master_transfer_sequencer_core #(
  parameter int TX_DEPTH = 16,
  parameter int RX_DEPTH = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  i2cms_req_if.sink    in_req,
  i2cms_res_if.source  out_res
);

  // front to queue
  logic            q_push;
  logic            q_full;
  i2cms_pkg::cmd_t q_push_cmd;

  // queue to back
  logic            q_pop;
  logic            q_head_valid;
  i2cms_pkg::cmd_t q_head_cmd;

  // front: handshake and request classification
  i2cms_front #(.RX_DEPTH(RX_DEPTH)) u_front (
    .req    (in_req),
    .q_full (q_full),
    .push   (q_push),
    .cmd    (q_push_cmd)
  );

  // decoupling queue so each side stalls on its own
  i2cms_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_cmd   (q_head_cmd)
  );

  // back: sequencer state, byte stores and result register
  i2cms_back #(.TX_DEPTH(TX_DEPTH), .RX_DEPTH(RX_DEPTH)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head_cmd   (q_head_cmd),
    .pop        (q_pop),
    .res        (out_res)
  );

endmodule

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for i2c_master_transfer_sequencer_core: drives write
// messages, reads, bus status events and fetches with random gaps and result
// stalls; a scoreboard predicts every result beat and checks it in order
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TX_DEPTH = 16;
  localparam int RX_DEPTH = 16;

  // status codes the package leaves unnamed
  localparam logic [3:0] ST_ADDR_R_ACK  = 4'd6;
  localparam logic [3:0] ST_ADDR_R_NACK = 4'd7;
  localparam logic [3:0] ST_NONE        = 4'd15;

  localparam int ITEM_TARGET = 1000;

  // one request as the bench sees it
  typedef struct {
    i2cms_pkg::op_t kind;
    logic [6:0]     addr;
    logic [7:0]     data;
    logic           last;
    logic [3:0]     rlen;
    logic [3:0]     status;
    logic [3:0]     fidx;
  } req_item_t;

  // --------------------------------------------------------------------------
  // scoreboard: mirrors the sequencer state and queues the expected controls
  // --------------------------------------------------------------------------
  class seq_scoreboard;
    logic [7:0]      tx_mem [TX_DEPTH];
    bit              tx_seen [TX_DEPTH];
    int              tx_fill, tx_pos, tx_len;
    logic [7:0]      rx_mem [RX_DEPTH];
    bit              rx_seen [RX_DEPTH];
    int              rx_pos, rx_len;
    logic [7:0]      addr_byte;
    bit              ack_lvl, irq_lvl;
    i2cms_pkg::res_t expected_q [$];
    int              errors;

    function new();
      tx_fill   = 0;
      tx_pos    = 0;
      tx_len    = 0;
      rx_pos    = 0;
      rx_len    = 0;
      addr_byte = '0;
      ack_lvl   = 1'b0;
      irq_lvl   = 1'b0;
      errors    = 0;
    endfunction

    // steer a request away from reading a store entry never written
    function req_item_t legal(req_item_t it);
      int j, k;
      if (it.kind == i2cms_pkg::REQ_STATUS &&
          (it.status == i2cms_pkg::ST_ADDR_W_ACK ||
           it.status == i2cms_pkg::ST_ADDR_W_NACK) &&
          tx_pos < TX_DEPTH && !tx_seen[tx_pos])
        it.status = i2cms_pkg::ST_START;
      if (it.kind == i2cms_pkg::REQ_FETCH && !rx_seen[it.fidx]) begin
        j = $urandom_range(0, RX_DEPTH - 1);
        for (k = 0; k < RX_DEPTH && !rx_seen[(j + k) % RX_DEPTH]; k++) ;
        if (k < RX_DEPTH) begin
          it.fidx = 4'((j + k) % RX_DEPTH);
        end else begin
          it.kind   = i2cms_pkg::REQ_STATUS;
          it.status = ST_NONE;
        end
      end
      return it;
    endfunction

    // next transmit byte; position holds once past the store
    function logic [7:0] next_tx();
      logic [7:0] v;
      v = '0;
      if (tx_pos < TX_DEPTH) begin
        v = tx_mem[tx_pos];
        tx_pos++;
      end
      return v;
    endfunction

    function void note_request(req_item_t it);
      i2cms_pkg::res_t r;
      r = '0;
      case (it.kind)
        i2cms_pkg::REQ_TX_BYTE: begin
          if (tx_len != 0) begin
            // write still pending, byte refused
          end else if (tx_fill >= TX_DEPTH) begin
            tx_fill = 0;
          end else begin
            tx_mem[tx_fill]  = it.data;
            tx_seen[tx_fill] = 1'b1;
            tx_fill++;
            r.accepted = 1'b1;
            if (it.last) begin
              tx_len       = tx_fill;
              tx_fill      = 0;
              addr_byte    = {it.addr, 1'b0};
              irq_lvl      = 1'b1;
              r.send_start = 1'b1;
            end
          end
        end
        i2cms_pkg::REQ_READ: begin
          if (it.rlen < RX_DEPTH) begin
            addr_byte    = {it.addr, 1'b1};
            rx_len       = it.rlen;
            rx_pos       = 0;
            irq_lvl      = 1'b1;
            ack_lvl      = 1'b1;
            r.send_start = 1'b1;
            r.accepted   = 1'b1;
          end
        end
        i2cms_pkg::REQ_STATUS: begin
          r.accepted     = 1'b1;
          r.release_flag = 1'b1;
          case (it.status)
            i2cms_pkg::ST_START, i2cms_pkg::ST_RSTART: begin
              r.load_data   = 1'b1;
              r.load_value  = addr_byte;
              r.clear_start = 1'b1;
            end
            i2cms_pkg::ST_ADDR_W_ACK, i2cms_pkg::ST_ADDR_W_NACK: begin
              r.load_data  = 1'b1;
              r.load_value = next_tx();
            end
            i2cms_pkg::ST_DATA_ACK, i2cms_pkg::ST_DATA_NACK: begin
              if (tx_pos < tx_len) begin
                r.load_data  = 1'b1;
                r.load_value = next_tx();
              end else begin
                tx_pos      = 0;
                tx_len      = 0;
                r.send_stop = 1'b1;
              end
            end
            i2cms_pkg::ST_RX_ACK: begin
              if (rx_pos < rx_len && rx_pos < RX_DEPTH) begin
                rx_mem[rx_pos]  = it.data;
                rx_seen[rx_pos] = 1'b1;
                rx_pos++;
              end else begin
                ack_lvl = 1'b0;
              end
            end
            i2cms_pkg::ST_RX_NACK: r.send_stop = 1'b1;
            default: ;
          endcase
        end
        default: begin
          r.accepted = 1'b1;
          if (it.fidx < RX_DEPTH) r.fetched_byte = rx_mem[it.fidx];
        end
      endcase
      r.ack_enabled    = ack_lvl;
      r.irq_enabled    = irq_lvl;
      r.received_count = 4'(rx_len);
      expected_q.push_back(r);
    endfunction

    function void cmp(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0h got %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(i2cms_pkg::res_t got);
      i2cms_pkg::res_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: result beat with nothing outstanding, got %0h", $time, got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      cmp("accepted",       want.accepted,       got.accepted);
      cmp("load_data",      want.load_data,      got.load_data);
      cmp("load_value",     want.load_value,     got.load_value);
      cmp("send_start",     want.send_start,     got.send_start);
      cmp("clear_start",    want.clear_start,    got.clear_start);
      cmp("send_stop",      want.send_stop,      got.send_stop);
      cmp("ack_enabled",    want.ack_enabled,    got.ack_enabled);
      cmp("irq_enabled",    want.irq_enabled,    got.irq_enabled);
      cmp("release_flag",   want.release_flag,   got.release_flag);
      cmp("fetched_byte",   want.fetched_byte,   got.fetched_byte);
      cmp("received_count", want.received_count, got.received_count);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  i2cms_req_if req_ch ();
  i2cms_res_if res_ch ();

  i2c_master_transfer_sequencer_core #(
    .TX_DEPTH (TX_DEPTH),
    .RX_DEPTH (RX_DEPTH)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_res (res_ch)
  );

  seq_scoreboard sb = new();

  int beats_in = 0;
  bit in_calm  = 1'b0;   // no gaps on the request side while set
  bit out_calm = 1'b0;   // no stalls on the result side while set

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // every field random, so unused fields toggle too
  function automatic req_item_t rand_item();
    req_item_t it;
    it.kind   = i2cms_pkg::op_t'($urandom_range(0, 3));
    it.addr   = 7'($urandom_range(0, 127));
    it.data   = 8'($urandom_range(0, 255));
    it.last   = 1'($urandom_range(0, 1));
    it.rlen   = 4'($urandom_range(0, 15));
    it.status = 4'($urandom_range(0, 15));
    it.fidx   = 4'($urandom_range(0, 15));
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // request driver: one beat per call, valid stays up between back-to-back
  // beats; called at a rising edge, returns at the edge that took the beat
  // --------------------------------------------------------------------------
  task automatic send(input req_item_t raw);
    req_item_t it;
    int gap;
    gap = in_calm ? 0 : gap_len();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    // predictor state only moves on accepted beats, so legalize now
    it = sb.legal(raw);
    req_ch.valid         <= 1'b1;
    req_ch.req_type      <= it.kind;
    req_ch.slave_address <= it.addr;
    req_ch.data_byte     <= it.data;
    req_ch.last_byte     <= it.last;
    req_ch.read_length   <= it.rlen;
    req_ch.bus_status    <= it.status;
    req_ch.fetch_index   <= it.fidx;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    sb.note_request(it);
    beats_in++;
  endtask

  task automatic send_tx(input logic [6:0] addr, input logic [7:0] data,
                         input logic last);
    req_item_t it;
    it      = rand_item();
    it.kind = i2cms_pkg::REQ_TX_BYTE;
    it.addr = addr;
    it.data = data;
    it.last = last;
    send(it);
  endtask

  task automatic send_read(input logic [6:0] addr, input logic [3:0] rlen);
    req_item_t it;
    it      = rand_item();
    it.kind = i2cms_pkg::REQ_READ;
    it.addr = addr;
    it.rlen = rlen;
    send(it);
  endtask

  task automatic send_status(input logic [3:0] status, input logic [7:0] data);
    req_item_t it;
    it        = rand_item();
    it.kind   = i2cms_pkg::REQ_STATUS;
    it.status = status;
    it.data   = data;
    send(it);
  endtask

  task automatic send_fetch(input logic [3:0] fidx);
    req_item_t it;
    it      = rand_item();
    it.kind = i2cms_pkg::REQ_FETCH;
    it.fidx = fidx;
    send(it);
  endtask

  // ack and not-ack flavors of one bus state, picked at random
  function automatic logic [3:0] either(input logic [3:0] ack_code,
                                        input logic [3:0] nack_code);
    return $urandom_range(0, 1) ? nack_code : ack_code;
  endfunction

  // --------------------------------------------------------------------------
  // directed opening: extremes, every request kind, the corner behaviors
  // --------------------------------------------------------------------------
  task automatic directed();
    send_status(ST_NONE, 8'h00);                 // quiet event before any traffic
    send_tx(7'h7F, 8'hFF, 1'b0);
    send_tx(7'h00, 8'h00, 1'b0);
    send_tx(7'h7F, 8'h5A, 1'b1);                 // last byte starts the write
    send_tx(7'h00, 8'hA5, 1'b1);                 // refused, write pending
    send_status(i2cms_pkg::ST_START, 8'hFF);     // address byte with w bit
    send_status(i2cms_pkg::ST_ADDR_W_NACK, 8'h00);
    send_status(i2cms_pkg::ST_DATA_ACK, 8'hFF);
    send_status(i2cms_pkg::ST_DATA_NACK, 8'h00);
    send_status(i2cms_pkg::ST_DATA_ACK, 8'h00);  // message done, stop
    send_read(7'h00, 4'd2);                      // address byte with r bit
    send_status(i2cms_pkg::ST_RSTART, 8'h00);
    send_status(ST_ADDR_R_NACK, 8'h00);
    send_status(i2cms_pkg::ST_RX_ACK, 8'hFF);
    send_status(i2cms_pkg::ST_RX_ACK, 8'h00);
    send_status(i2cms_pkg::ST_RX_ACK, 8'h3C);    // receive full drops ack
    send_status(i2cms_pkg::ST_RX_NACK, 8'h00);
    send_fetch(4'd0);
    send_fetch(4'd1);
    send_read(7'h7F, 4'd15);                     // longest read
    send_read(7'h55, 4'd0);                      // empty read
    send_status(i2cms_pkg::ST_RX_ACK, 8'h81);
    send_status(ST_ADDR_R_ACK, 8'h00);
    send_fetch(4'd15);                           // redirected to a written entry
  endtask

  // --------------------------------------------------------------------------
  // random sequences
  // --------------------------------------------------------------------------
  task automatic write_txn();
    int n, i, guard;
    logic [6:0] addr;
    addr = 7'($urandom_range(0, 127));
    // occasionally overrun the transmit store first, dropping the partial message
    if ($urandom_range(0, 19) == 0) begin
      for (i = 0; i <= TX_DEPTH; i++) send_tx(addr, 8'($urandom), 1'b0);
    end
    n = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(5, TX_DEPTH);
    for (i = 0; i < n; i++) send_tx(addr, 8'($urandom), i == n - 1);
    send_status(either(i2cms_pkg::ST_START, i2cms_pkg::ST_RSTART), 8'($urandom));
    send_status(either(i2cms_pkg::ST_ADDR_W_ACK, i2cms_pkg::ST_ADDR_W_NACK),
                8'($urandom));
    // extra address events walk the position, sometimes past the store
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 20))
        send_status(either(i2cms_pkg::ST_ADDR_W_ACK, i2cms_pkg::ST_ADDR_W_NACK),
                    8'($urandom));
    end
    guard = 0;
    while (sb.tx_len != 0 && guard < 40) begin
      if ($urandom_range(0, 29) == 0) break;     // abandoned mid-message
      send_status(either(i2cms_pkg::ST_DATA_ACK, i2cms_pkg::ST_DATA_NACK),
                  8'($urandom));
      guard++;
    end
  endtask

  task automatic read_txn();
    int n, i, extra;
    n = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 4) : $urandom_range(5, 15);
    send_read(7'($urandom_range(0, 127)), 4'(n));
    send_status(either(i2cms_pkg::ST_START, i2cms_pkg::ST_RSTART), 8'($urandom));
    send_status(either(ST_ADDR_R_ACK, ST_ADDR_R_NACK), 8'($urandom));
    extra = ($urandom_range(0, 9) == 0) ? -$urandom_range(0, n) : $urandom_range(0, 2);
    for (i = 0; i < n + extra; i++) send_status(i2cms_pkg::ST_RX_ACK, 8'($urandom));
    if ($urandom_range(0, 9) != 0) send_status(i2cms_pkg::ST_RX_NACK, 8'($urandom));
    repeat ($urandom_range(0, n + 1)) send_fetch(4'($urandom_range(0, 15)));
  endtask

  // --------------------------------------------------------------------------
  // result side: random stalls, every beat checked against the scoreboard
  // --------------------------------------------------------------------------
  initial begin : result_side
    int              left;
    bit              rdy;
    i2cms_pkg::res_t got;
    left = 0;
    rdy  = 1'b0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
        // packed in res_t field order
        got = {res_ch.accepted, res_ch.load_data, res_ch.load_value,
               res_ch.send_start, res_ch.clear_start, res_ch.send_stop,
               res_ch.ack_enabled, res_ch.irq_enabled, res_ch.release_flag,
               res_ch.fetched_byte, res_ch.received_count};
        sb.check_result(got);
      end
      if ($urandom_range(0, 299) == 0) out_calm = !out_calm;
      if (rst_n !== 1'b1) begin
        rdy = 1'b0;
      end else if (left > 0) begin
        left--;
      end else if (rdy) begin
        left = out_calm ? 0 : gap_len();
        if (left > 0) begin
          rdy = 1'b0;
          left--;
        end else begin
          left = $urandom_range(0, 15);
        end
      end else begin
        rdy  = 1'b1;
        left = $urandom_range(0, 15);
      end
      res_ch.ready <= rdy;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int k, p;
    rst_n                <= 1'b0;
    req_ch.valid         <= 1'b0;
    req_ch.req_type      <= i2cms_pkg::REQ_TX_BYTE;
    req_ch.slave_address <= '0;
    req_ch.data_byte     <= '0;
    req_ch.last_byte     <= 1'b0;
    req_ch.read_length   <= '0;
    req_ch.bus_status    <= ST_NONE;
    req_ch.fetch_index   <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    directed();

    while (beats_in < ITEM_TARGET) begin
      in_calm = ($urandom_range(0, 5) == 0);
      p = $urandom_range(0, 99);
      if (p < 40) begin
        write_txn();
      end else if (p < 75) begin
        read_txn();
      end else begin
        repeat ($urandom_range(1, 6)) send(rand_item());
      end
    end

    req_ch.valid <= 1'b0;
    // drain, then idle for anything stray behind the last result
    for (k = 0; k < 50000 && sb.expected_q.size() != 0; k++) @(posedge clk);
    repeat (12) @(posedge clk);
    if (sb.expected_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, sb.expected_q.size());
      sb.errors++;
    end
    if (sb.errors == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

  // hard stop if the handshakes hang
  initial begin : watchdog
    #4_000_000;
    $display("tb NOT OK");
    $finish;
  end

endmodule

// File: i2c_master_transfer_sequencer_core.f
rtl/i2cms_pkg.sv
rtl/i2cms_req_if.sv
rtl/i2cms_res_if.sv
rtl/i2cms_ram.sv
rtl/i2cms_front.sv
rtl/i2cms_queue.sv
rtl/i2cms_back.sv
rtl/i2c_master_transfer_sequencer_core.sv
dv/tb.sv
